// File: hdl/crsc_pkg.sv
`default_nettype none
package crsc_pkg;

	localparam int SECTOR_W = 32;
	localparam int SLOT_W   = 3;
	localparam int CNT_W    = 32;
	localparam int OP_W     = 2;
	localparam int IN_W     = 32;
	localparam int OUT_W    = 104;

	localparam logic [OP_W-1:0] OP_READ  = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
	localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

	typedef struct packed {
		logic [2:0]          pad;
		logic [CNT_W-1:0]    miss_total;
		logic [CNT_W-1:0]    hit_total;
		logic                write_back;
		logic [SECTOR_W-1:0] victim_sector;
		logic                victim_valid;
		logic [SLOT_W-1:0]   slot;
	} result_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == '1) ? v : v + CNT_W'(1);
	endfunction

endpackage
`default_nettype wire

// File: hdl/clock_replacement_sector_cache.sv
// Operation: a read or write first compares the stored tags in order, one tag compared per
// cycle; a miss then sweeps the hand and fills the chosen slot; a flush visits each slot in
// turn and emits one result per valid slot, the last one marked with m_tlast.
// One request at a time: s_tready is high only when idle, and a stalled output holds the block.
// Reset (arst_n low, asynchronous): all slots invalid, unreferenced and clean,
// hand and counters zero; the tag memory is not cleared.
`default_nettype none
module clock_replacement_sector_cache
	import crsc_pkg::*;
#(
	parameter int ENTRIES = 8
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	output logic                 s_tready,
	input  wire  [IN_W-1:0]      s_tdata,   // sector[31:0]
	input  wire  [OP_W-1:0]      s_tuser,   // opcode[1:0]
	output logic                 m_tvalid,
	input  wire                  m_tready,
	output logic [OUT_W-1:0]     m_tdata,   // slot[2:0], victim_valid[3], victim_sector[35:4],
	                                        // write_back[36], hit_total[68:37],
	                                        // miss_total[100:69], zero[103:101]
	output logic                 m_tuser,   // hit[0]
	output logic                 m_tlast
);

	localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = SW + 1;
	localparam logic [CW-1:0] LAST_CNT = CW'(ENTRIES);
	localparam logic [SW-1:0] TOP_IDX  = SW'(ENTRIES - 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_LOOKUP = 3'd1;
	localparam logic [2:0] ST_SWEEP  = 3'd2;
	localparam logic [2:0] ST_FILL   = 3'd3;
	localparam logic [2:0] ST_FLUSH  = 3'd4;
	localparam logic [2:0] ST_FEMIT  = 3'd5;
	localparam logic [2:0] ST_OUT    = 3'd6;

	logic [2:0]          state_q;
	logic [CW-1:0]       idx_q;
	logic [CW-1:0]       cnt_q;
	logic [SW-1:0]       hand_q;
	logic [OP_W-1:0]     op_q;
	logic [SECTOR_W-1:0] sector_q;
	logic                flush_q;
	logic [ENTRIES-1:0]  valid_q;
	logic [ENTRIES-1:0]  ref_q;
	logic [ENTRIES-1:0]  dirty_q;
	logic [CNT_W-1:0]    hit_cnt_q;
	logic [CNT_W-1:0]    miss_cnt_q;

	logic [SECTOR_W-1:0] tag_mem [ENTRIES];
	logic [SECTOR_W-1:0] rd_q;
	logic [SW-1:0]       rd_addr;

	result_t             res_q;
	logic                res_hit_q;
	logic                res_last_q;

	logic [SW-1:0]       cmp_idx;
	logic [SW-1:0]       idx_lo;
	logic [SW-1:0]       hand_nx;
	logic                lookup_hit;
	logic                sweep_take;
	logic [ENTRIES-1:0]  idx_mask;

	assign idx_lo     = idx_q[SW-1:0];
	assign cmp_idx    = idx_lo - SW'(1);
	assign lookup_hit = (idx_q != '0) && valid_q[cmp_idx] && (rd_q == sector_q);
	assign sweep_take = (cnt_q == LAST_CNT) || !valid_q[hand_q] || !ref_q[hand_q];
	assign hand_nx    = (hand_q == TOP_IDX) ? '0 : hand_q + SW'(1);
	assign idx_mask   = ENTRIES'(1) << idx_lo;

	always_comb begin
		rd_addr = '0;
		unique case (state_q)
			ST_LOOKUP, ST_FLUSH: begin
				if (idx_q < LAST_CNT) rd_addr = idx_lo;
			end
			ST_SWEEP: rd_addr = hand_q;
			default:  rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		rd_q <= tag_mem[rd_addr];
		if (state_q == ST_FILL) tag_mem[hand_q] <= sector_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			cnt_q      <= '0;
			hand_q     <= '0;
			flush_q    <= 1'b0;
			valid_q    <= '0;
			ref_q      <= '0;
			dirty_q    <= '0;
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						idx_q   <= '0;
						flush_q <= (s_tuser == OP_FLUSH);
						if (s_tuser == OP_FLUSH) state_q <= ST_FLUSH;
						else if (s_tuser == OP_READ || s_tuser == OP_WRITE) state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					if (lookup_hit) begin
						ref_q[cmp_idx] <= 1'b1;
						if (op_q == OP_WRITE) dirty_q[cmp_idx] <= 1'b1;
						hit_cnt_q <= sat_inc(hit_cnt_q);
						state_q   <= ST_OUT;
					end else if (idx_q == LAST_CNT) begin
						cnt_q   <= '0;
						state_q <= ST_SWEEP;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				ST_SWEEP: begin
					if (sweep_take) begin
						state_q <= ST_FILL;
					end else begin
						ref_q[hand_q] <= 1'b0;
						hand_q        <= hand_nx;
						cnt_q         <= cnt_q + CW'(1);
					end
				end
				ST_FILL: begin
					valid_q[hand_q] <= 1'b1;
					ref_q[hand_q]   <= 1'b1;
					dirty_q[hand_q] <= (op_q == OP_WRITE);
					miss_cnt_q      <= sat_inc(miss_cnt_q);
					state_q         <= ST_OUT;
				end
				ST_FLUSH: begin
					if (valid_q == '0) state_q <= ST_IDLE;
					else if (valid_q[idx_lo]) state_q <= ST_FEMIT;
					else idx_q <= idx_q + CW'(1);
				end
				ST_FEMIT: begin
					valid_q[idx_lo] <= 1'b0;
					ref_q[idx_lo]   <= 1'b0;
					dirty_q[idx_lo] <= 1'b0;
					idx_q           <= idx_q + CW'(1);
					state_q         <= ST_OUT;
				end
				ST_OUT: begin
					if (m_tready) state_q <= flush_q ? ST_FLUSH : ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			op_q     <= s_tuser;
			sector_q <= s_tdata;
		end
		unique case (state_q)
			ST_LOOKUP: begin
				res_hit_q           <= 1'b1;
				res_last_q          <= 1'b1;
				res_q.pad           <= '0;
				res_q.slot          <= SLOT_W'(cmp_idx);
				res_q.victim_valid  <= 1'b0;
				res_q.victim_sector <= '0;
				res_q.write_back    <= 1'b0;
				res_q.hit_total     <= sat_inc(hit_cnt_q);
				res_q.miss_total    <= miss_cnt_q;
			end
			ST_FILL: begin
				res_hit_q           <= 1'b0;
				res_last_q          <= 1'b1;
				res_q.pad           <= '0;
				res_q.slot          <= SLOT_W'(hand_q);
				res_q.victim_valid  <= valid_q[hand_q];
				res_q.victim_sector <= valid_q[hand_q] ? rd_q : '0;
				res_q.write_back    <= valid_q[hand_q] && dirty_q[hand_q];
				res_q.hit_total     <= hit_cnt_q;
				res_q.miss_total    <= sat_inc(miss_cnt_q);
			end
			ST_FEMIT: begin
				res_hit_q           <= 1'b0;
				res_last_q          <= ((valid_q & ~idx_mask) == '0);
				res_q.pad           <= '0;
				res_q.slot          <= SLOT_W'(idx_lo);
				res_q.victim_valid  <= 1'b1;
				res_q.victim_sector <= rd_q;
				res_q.write_back    <= dirty_q[idx_lo];
				res_q.hit_total     <= hit_cnt_q;
				res_q.miss_total    <= miss_cnt_q;
			end
			default: begin
			end
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = res_q;
	assign m_tuser  = res_hit_q;
	assign m_tlast  = res_last_q;

endmodule
`default_nettype wire

// File: hdl/crsc_checker.sv
`default_nettype none
module crsc_checker
	import crsc_pkg::*;
(
	input wire             clk,
	input wire             arst_n,
	input wire             s_tready,
	input wire             m_tvalid,
	input wire             m_tready,
	input wire [OUT_W-1:0] m_tdata,
	input wire             m_tuser,
	input wire             m_tlast
);

	result_t res;
	assign res = m_tdata;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("result changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("request taken while a result is pending");

	a_hit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> !res.victim_valid && !res.write_back && m_tlast)
		else $error("hit result carries an eviction");

	a_flush_body: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> res.victim_valid && !m_tuser)
		else $error("non-final result is not a flush eviction");

endmodule

bind clock_replacement_sector_cache crsc_checker u_crsc_checker (.*);
`default_nettype wire

// File: sim/clock_replacement_sector_cache_tb.sv
`timescale 1ns / 100ps
module clock_replacement_sector_cache_tb;
	import crsc_pkg::*;

	localparam int NSLOTS = 8;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_REQUESTS = 160;
	localparam int POOL = 12;

	typedef struct {
		logic                hit;
		logic [SLOT_W-1:0]   slot;
		logic                victim_valid;
		logic [SECTOR_W-1:0] victim_sector;
		logic                write_back;
		logic                last;
		logic [CNT_W-1:0]    hit_total;
		logic [CNT_W-1:0]    miss_total;
	} cache_outcome_t;

	class clock_cache_board;
		logic [SECTOR_W-1:0] tags [NSLOTS];
		bit valid [NSLOTS];
		bit referenced [NSLOTS];
		bit dirty [NSLOTS];
		int unsigned hand;
		logic [CNT_W-1:0] hit_count;
		logic [CNT_W-1:0] miss_count;
		cache_outcome_t outcomes [$];
		int unsigned failures;
		int unsigned checked;
		int unsigned hits_seen;
		int unsigned evictions;
		int unsigned write_backs;

		function new();
			foreach (valid[i]) begin
				tags[i] = '0;
				valid[i] = 1'b0;
				referenced[i] = 1'b0;
				dirty[i] = 1'b0;
			end
			hand = 0;
			hit_count = '0;
			miss_count = '0;
			failures = 0;
			checked = 0;
			hits_seen = 0;
			evictions = 0;
			write_backs = 0;
		endfunction

		function void note_request(logic [OP_W-1:0] op, logic [SECTOR_W-1:0] sector);
			cache_outcome_t o;
			int last_valid;
			int slot;
			int k;
			bit found;
			last_valid = -1;
			slot = 0;
			found = 1'b0;
			if (op == OP_FLUSH) begin
				foreach (valid[i])
					if (valid[i]) last_valid = i;
				foreach (valid[i]) begin
					if (valid[i]) begin
						o.hit = 1'b0;
						o.slot = SLOT_W'(i);
						o.victim_valid = 1'b1;
						o.victim_sector = tags[i];
						o.write_back = dirty[i];
						o.last = (i == last_valid);
						o.hit_total = hit_count;
						o.miss_total = miss_count;
						outcomes.push_back(o);
						valid[i] = 1'b0;
						referenced[i] = 1'b0;
						dirty[i] = 1'b0;
					end
				end
			end else if (op == OP_READ || op == OP_WRITE) begin
				foreach (valid[i])
					if (!found && valid[i] && tags[i] == sector) begin
						found = 1'b1;
						slot = i;
					end
				o.victim_valid = 1'b0;
				o.victim_sector = '0;
				o.write_back = 1'b0;
				if (found) begin
					if (hit_count != '1) hit_count = hit_count + 1;
				end else begin
					if (miss_count != '1) miss_count = miss_count + 1;
					k = 0;
					while (k < NSLOTS && valid[hand] && referenced[hand]) begin
						referenced[hand] = 1'b0;
						hand = (hand + 1) % NSLOTS;
						k++;
					end
					slot = hand;
					if (valid[slot]) begin
						o.victim_valid = 1'b1;
						o.victim_sector = tags[slot];
						o.write_back = dirty[slot];
					end
					tags[slot] = sector;
					valid[slot] = 1'b1;
					dirty[slot] = 1'b0;
				end
				referenced[slot] = 1'b1;
				if (op == OP_WRITE) dirty[slot] = 1'b1;
				o.hit = found;
				o.slot = SLOT_W'(slot);
				o.last = 1'b1;
				o.hit_total = hit_count;
				o.miss_total = miss_count;
				outcomes.push_back(o);
			end
		endfunction

		function void compare(string field, logic [SECTOR_W-1:0] want, logic [SECTOR_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", field, want, got);
				failures++;
			end
		endfunction

		function void check_result(logic hit, logic last, result_t r);
			cache_outcome_t o;
			if (outcomes.size() == 0) begin
				$error("unexpected result: slot %0d, hit %0b", r.slot, hit);
				failures++;
				return;
			end
			o = outcomes.pop_front();
			checked++;
			if (o.hit) hits_seen++;
			if (o.victim_valid) evictions++;
			if (o.write_back) write_backs++;
			compare("hit", o.hit, hit);
			compare("slot", o.slot, r.slot);
			compare("victim_valid", o.victim_valid, r.victim_valid);
			compare("victim_sector", o.victim_sector, r.victim_sector);
			compare("write_back", o.write_back, r.write_back);
			compare("last", o.last, last);
			compare("hit_total", o.hit_total, r.hit_total);
			compare("miss_total", o.miss_total, r.miss_total);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic [IN_W-1:0] s_tdata = '0;
	logic [OP_W-1:0] s_tuser = OP_READ;
	logic m_tready = 1'b0;
	wire s_tready;
	wire m_tvalid;
	wire [OUT_W-1:0] m_tdata;
	wire m_tuser;
	wire m_tlast;

	bit calm = 1'b0;
	int unsigned cycles = 0;
	int unsigned accesses = 0;
	int unsigned flushes = 0;
	int unsigned ignored = 0;
	clock_cache_board board = new();

	clock_replacement_sector_cache #(
		.ENTRIES(NSLOTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("clock_replacement_sector_cache test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tuser, m_tlast, result_t'(m_tdata));
		m_tready <= calm || ($urandom_range(99) >= 34);
	end

	task automatic push_request(input logic [OP_W-1:0] op, input logic [SECTOR_W-1:0] sector);
		if (!calm && $urandom_range(99) < 34) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= sector;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_request(op, sector);
		if (op == OP_FLUSH) flushes++;
		else if (op == OP_UNUSED) ignored++;
		else accesses++;
	endtask

	// hold the sender until every pending result has arrived
	task automatic await_drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.outcomes.size() != 0) @(posedge clk);
	endtask

	initial begin
		logic [SECTOR_W-1:0] pool [POOL];
		logic [SECTOR_W-1:0] sector;
		logic [OP_W-1:0] op;
		int n;
		int roll;
		bit paused;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_request(OP_FLUSH, 32'h0000_0000);
		push_request(OP_UNUSED, 32'hFFFF_FFFF);
		push_request(OP_READ, 32'h0000_0000);
		push_request(OP_WRITE, 32'hFFFF_FFFF);
		push_request(OP_READ, 32'h0000_0000);
		push_request(OP_WRITE, 32'h0000_0000);
		for (n = 1; n <= 6; n++)
			push_request(n[0] ? OP_WRITE : OP_READ, 32'h8000_0000 | n);
		push_request(OP_READ, 32'h5555_5555);
		push_request(OP_WRITE, 32'hAAAA_AAAA);
		push_request(OP_READ, 32'h8000_0002);
		push_request(OP_UNUSED, 32'h1234_5678);
		push_request(OP_FLUSH, 32'hFFFF_FFFF);
		push_request(OP_FLUSH, 32'h0000_0000);
		push_request(OP_READ, 32'hFFFF_FFFF);
		push_request(OP_WRITE, 32'h7FFF_FFFE);

		foreach (pool[i]) pool[i] = $urandom();
		n = 0;
		paused = 1'b0;
		while (n < RANDOM_REQUESTS) begin
			calm = (n >= 100 && n < 140);
			if (n == 60 && !paused) begin
				await_drain();
				paused = 1'b1;
			end
			roll = $urandom_range(99);
			if (roll < 4) op = OP_FLUSH;
			else if (roll < 7) op = OP_UNUSED;
			else op = $urandom_range(1) ? OP_WRITE : OP_READ;
			if ($urandom_range(99) < 5) pool[$urandom_range(POOL - 1)] = $urandom();
			sector = ($urandom_range(99) < 75) ? pool[$urandom_range(POOL - 1)] : $urandom();
			push_request(op, sector);
			if (op != OP_UNUSED) n++;
		end
		calm = 1'b0;

		await_drain();
		repeat (4 * NSLOTS) @(posedge clk);

		$display("%0d reads/writes, %0d flushes, %0d ignored opcodes sent", accesses, flushes,
			ignored);
		$display("%0d results checked: %0d hits, %0d evictions, %0d write-backs",
			board.checked, board.hits_seen, board.evictions, board.write_backs);
		if (board.failures == 0 && board.outcomes.size() == 0) begin
			$display("clock_replacement_sector_cache test passed");
		end else begin
			$display("clock_replacement_sector_cache test failed");
		end
		$finish;
	end

endmodule

// File: sim.f
hdl/crsc_pkg.sv
hdl/clock_replacement_sector_cache.sv
hdl/crsc_checker.sv
sim/clock_replacement_sector_cache_tb.sv
